[rtl/core/tbi_pkg.sv]
// Shared types and constants for the trinomial backward induction block.
// Depends on nothing; front, back and top level take their names from here.
`timescale 1ns / 1ps

package tbi_pkg;

  // Default number of nodes a single tree level may store.
  localparam int unsigned MaxNodesDefault = 1024;

  // Request codes carried in req_type.
  localparam logic ReqTerminal = 1'b0;
  localparam logic ReqInterior = 1'b1;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Width of the count of items between acceptance and the store write.
  // At most seven are in flight: the queue plus three back stages.
  localparam int unsigned InflightW = 4;

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic               req_type;
    logic [15:0]        prob_down;
    logic [15:0]        prob_mid;
    logic [15:0]        prob_up;
    logic [9:0]         child_index;
    logic signed [31:0] exercise_value;
    logic               level_last;
    logic [9:0]         node_index;
    logic               index_error;
    logic               store;
    logic               rd_bank;
    logic               wr_bank;
  } node_item_t;

endpackage

[rtl/core/tbi_if.sv]
// Handshake channels of the trinomial backward induction block.
// Depends on nothing; used by the top level, the front and the back.
`timescale 1ns / 1ps

// Node items going into the block.
interface tbi_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [15:0]        prob_down;
  logic [15:0]        prob_mid;
  logic [15:0]        prob_up;
  logic [9:0]         child_index;
  logic signed [31:0] exercise_value;
  logic               level_last;

  modport source (output valid, req_type, prob_down, prob_mid, prob_up, child_index,
                  exercise_value, level_last, input ready);
  modport sink   (input valid, req_type, prob_down, prob_mid, prob_up, child_index,
                  exercise_value, level_last, output ready);
endinterface

// Node value items coming out of the block.
interface tbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] node_value;
  logic [9:0]         node_index;
  logic               level_done;
  logic               index_error;

  modport source (output valid, node_value, node_index, level_done, index_error,
                  input ready);
  modport sink   (input valid, node_value, node_index, level_done, index_error,
                  output ready);
endinterface

[rtl/core/tbi_front.sv]
// Front of the block: accepts node items, tracks level position and banks,
// checks child range. Depends on tbi_pkg and tbi_in_if.
`timescale 1ns / 1ps

module tbi_front #(
  parameter int unsigned MaxNodes = tbi_pkg::MaxNodesDefault,
  parameter int unsigned AddrW    = $clog2(MaxNodes)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tbi_in_if.sink               in_i,
  input  logic                 full_i,
  input  logic                 retire_i,
  output logic                 push_o,
  output tbi_pkg::node_item_t  item_o,
  output logic [AddrW-1:0]     wpos_o
);

  localparam int unsigned PosW = $clog2(MaxNodes + 1);

  logic [PosW-1:0]               wpos_q, wpos_d;
  logic [PosW-1:0]               prev_size_q, prev_size_d;
  logic                          bank_q, bank_d;
  logic                          pending_q, pending_d;
  logic [tbi_pkg::InflightW-1:0] inflight_q, inflight_d;
  logic                          accept;
  logic                          store;
  logic                          err;
  logic [PosW-1:0]               pos_next;

  // After a level end, hold input until every earlier item has reached the store.
  assign in_i.ready = !full_i && !(pending_q && (inflight_q != '0));
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  // Classification of the item against the level completed last.
  assign store    = (wpos_q < PosW'(MaxNodes));
  assign err      = (in_i.child_index == 10'd0) ||
                    ((32'(in_i.child_index) + 32'd1) >= 32'(prev_size_q));
  assign pos_next = store ? (wpos_q + PosW'(1)) : wpos_q;

  always_comb begin
    item_o.req_type       = in_i.req_type;
    item_o.prob_down      = in_i.prob_down;
    item_o.prob_mid       = in_i.prob_mid;
    item_o.prob_up        = in_i.prob_up;
    item_o.child_index    = in_i.child_index;
    item_o.exercise_value = in_i.exercise_value;
    item_o.level_last     = in_i.level_last;
    item_o.node_index     = 10'(wpos_q);
    item_o.index_error    = err;
    item_o.store          = store;
    item_o.rd_bank        = ~bank_q;
    item_o.wr_bank        = bank_q;
  end

  assign wpos_o = wpos_q[AddrW-1:0];

  // Level bookkeeping.
  always_comb begin
    wpos_d      = wpos_q;
    prev_size_d = prev_size_q;
    bank_d      = bank_q;
    if (accept) begin
      if (in_i.level_last) begin
        prev_size_d = pos_next;
        wpos_d      = '0;
        bank_d      = ~bank_q;
      end else begin
        wpos_d = pos_next;
      end
    end
  end

  // Count of items accepted but not yet written to the store.
  always_comb begin
    inflight_d = inflight_q + tbi_pkg::InflightW'(accept) - tbi_pkg::InflightW'(retire_i);
    pending_d  = pending_q;
    if (accept && in_i.level_last) begin
      pending_d = 1'b1;
    end else if (inflight_q == '0) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      prev_size_q <= '0;
      bank_q      <= 1'b0;
      pending_q   <= 1'b0;
      inflight_q  <= '0;
    end else begin
      wpos_q      <= wpos_d;
      prev_size_q <= prev_size_d;
      bank_q      <= bank_d;
      pending_q   <= pending_d;
      inflight_q  <= inflight_d;
    end
  end

endmodule

[rtl/core/tbi_queue.sv]
// Short first-in first-out queue between the front and the back.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module tbi_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/tbi_back.sv]
// Back of the block: reads the three children, forms the weighted sum,
// applies early exercise, writes the store and holds the result item.
// Depends on tbi_pkg and tbi_out_if.
`timescale 1ns / 1ps

module tbi_back #(
  parameter int unsigned AddrW = $clog2(tbi_pkg::MaxNodesDefault)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  tbi_pkg::node_item_t item_i,
  input  logic [AddrW-1:0]    wpos_i,
  output logic                pop_o,
  output logic                retire_o,
  tbi_out_if.source           out_o
);

  localparam int unsigned Depth = 2 ** (AddrW + 1);
  localparam logic signed [34:0] SatMax = 35'sd2147483647;
  localparam logic signed [34:0] SatMin = -35'sd2147483648;

  // One copy of the ping-pong store per child read port.
  logic [31:0] mem_dn  [Depth];
  logic [31:0] mem_mid [Depth];
  logic [31:0] mem_up  [Depth];

  logic advance;

  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  tbi_pkg::node_item_t s1_item_q, s2_item_q, s3_item_q;
  logic [AddrW-1:0]    s1_wpos_q, s2_wpos_q, s3_wpos_q;

  logic [AddrW+9:0]    c_ext;
  logic [AddrW-1:0]    c_mid, c_dn, c_up;
  logic [31:0]         rd_dn_q, rd_mid_q, rd_up_q;

  logic signed [16:0]  pd_s, pm_s, pu_s;
  logic signed [48:0]  prod_dn_q, prod_mid_q, prod_up_q;
  logic signed [50:0]  sum_w;
  logic signed [34:0]  rsum_q;
  logic signed [31:0]  sat_w, val_w;

  logic                out_valid_q;
  logic signed [31:0]  out_value_q;
  logic [9:0]          out_index_q;
  logic                out_last_q;
  logic                out_err_q;

  // The whole back moves together whenever the output register can take an item.
  assign advance  = !out_valid_q || out_o.ready;
  assign pop_o    = advance && !empty_i;
  assign retire_o = advance && s3_valid_q;

  // Child addresses in the bank completed last.
  assign c_ext = {{AddrW{1'b0}}, item_i.child_index};
  assign c_mid = c_ext[AddrW-1:0];
  assign c_dn  = c_mid - AddrW'(1);
  assign c_up  = c_mid + AddrW'(1);

  // Store reads, registered as the item enters the first stage.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_dn_q  <= mem_dn[{item_i.rd_bank, c_dn}];
      rd_mid_q <= mem_mid[{item_i.rd_bank, c_mid}];
      rd_up_q  <= mem_up[{item_i.rd_bank, c_up}];
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Probabilities as non-negative signed factors.
  assign pd_s = $signed({1'b0, s1_item_q.prob_down});
  assign pm_s = $signed({1'b0, s1_item_q.prob_mid});
  assign pu_s = $signed({1'b0, s1_item_q.prob_up});

  // Exact sum in Q16.32, then round half up to Q16.16 by a floor shift.
  assign sum_w = 51'(prod_dn_q) + 51'(prod_mid_q) + 51'(prod_up_q) + 51'sd32768;

  // Stage payloads: products in the second stage, rounded sum in the third.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q  <= item_i;
      s1_wpos_q  <= wpos_i;
      s2_item_q  <= s1_item_q;
      s2_wpos_q  <= s1_wpos_q;
      prod_dn_q  <= pd_s * $signed(rd_dn_q);
      prod_mid_q <= pm_s * $signed(rd_mid_q);
      prod_up_q  <= pu_s * $signed(rd_up_q);
      s3_item_q  <= s2_item_q;
      s3_wpos_q  <= s2_wpos_q;
      rsum_q     <= sum_w[50:16];
    end
  end

  // Saturation and early exercise.
  always_comb begin
    priority if (rsum_q > SatMax) begin
      sat_w = SatMax[31:0];
    end else if (rsum_q < SatMin) begin
      sat_w = SatMin[31:0];
    end else begin
      sat_w = rsum_q[31:0];
    end
    if ((s3_item_q.req_type == tbi_pkg::ReqTerminal) || s3_item_q.index_error) begin
      val_w = s3_item_q.exercise_value;
    end else if (sat_w < s3_item_q.exercise_value) begin
      val_w = s3_item_q.exercise_value;
    end else begin
      val_w = sat_w;
    end
  end

  // Store write into the bank of the current level.
  always_ff @(posedge clk_i) begin
    if (retire_o && s3_item_q.store) begin
      mem_dn[{s3_item_q.wr_bank, s3_wpos_q}]  <= val_w;
      mem_mid[{s3_item_q.wr_bank, s3_wpos_q}] <= val_w;
      mem_up[{s3_item_q.wr_bank, s3_wpos_q}]  <= val_w;
    end
  end

  // Output register; terminal items leave no result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q && (s3_item_q.req_type == tbi_pkg::ReqInterior);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_value_q <= val_w;
      out_index_q <= s3_item_q.node_index;
      out_last_q  <= s3_item_q.level_last;
      out_err_q   <= s3_item_q.index_error;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.node_value  = out_value_q;
  assign out_o.node_index  = out_index_q;
  assign out_o.level_done  = out_last_q;
  assign out_o.index_error = out_err_q;

endmodule

[rtl/core/trinomial_backward_induction.sv]
// Top level of the trinomial backward induction block: front, queue and back.
// Depends on tbi_pkg, tbi_if, tbi_front, tbi_queue and tbi_back.
//
//   Channel   Direction  Moves                          Accepted when
//   in_i      in         one tree node item             in_i.valid && in_i.ready
//   out_o     out        one node value per interior    out_o.valid && out_o.ready
//
// Within a level one item is taken per cycle while the output does not stall; a
// result passes through the queue, the back stages and the output register.
// At each level end the front holds input until the store holds the whole
// finished level, which the store write at the end of the back completes;
// the hold lasts longer while the output stalls.
// A stalled output holds the back; the four-entry queue keeps taking until full.
// Reset clears control state only; the store holds nothing defined until written.
`timescale 1ns / 1ps

module trinomial_backward_induction #(
  parameter int unsigned MAX_NODES = tbi_pkg::MaxNodesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbi_in_if.sink    in_i,
  tbi_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MAX_NODES);
  localparam int unsigned QW    = $bits(tbi_pkg::node_item_t) + AddrW;

  logic                full, empty, push, pop, retire;
  tbi_pkg::node_item_t front_item, back_item;
  logic [AddrW-1:0]    front_wpos, back_wpos;
  logic [QW-1:0]       q_head;

  tbi_front #(
    .MaxNodes (MAX_NODES),
    .AddrW    (AddrW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .retire_i (retire),
    .push_o   (push),
    .item_o   (front_item),
    .wpos_o   (front_wpos)
  );

  tbi_queue #(
    .Width (QW),
    .Depth (tbi_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_item, front_wpos}),
    .pop_i   (pop),
    .data_o  (q_head),
    .full_o  (full),
    .empty_o (empty)
  );

  assign back_item = q_head[QW-1:AddrW];
  assign back_wpos = q_head[AddrW-1:0];

  tbi_back #(
    .AddrW (AddrW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .item_i   (back_item),
    .wpos_i   (back_wpos),
    .pop_o    (pop),
    .retire_o (retire),
    .out_o    (out_o)
  );

endmodule

[rtl/core/tbi_checker.sv]
// Port-level checks for the trinomial backward induction block, bound to the top.
// Depends on trinomial_backward_induction and the tbi_if channels.
`timescale 1ns / 1ps

module tbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic [9:0]  out_index_i
);

  // No result item is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result item offered during reset");

  // A result item that waits stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn while stalled");

  // A result item that waits keeps its value and position.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_index_i))
    else $error("result item changed while stalled");

  // After a level end the input pauses while the finished level reaches the store.
  a_level_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken straight after a level end");

endmodule

bind trinomial_backward_induction tbi_checker u_tbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.level_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.node_value),
  .out_index_i (out_o.node_index)
);

[bench/tb_trinomial_backward_induction.sv]
// Self-checking testbench for the trinomial backward induction block.
// Depends on tbi_pkg, tbi_if and the block itself; it predicts every node value.
`timescale 1ns / 1ps

module tb_trinomial_backward_induction;

  localparam int unsigned MaxNodes = tbi_pkg::MaxNodesDefault;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;
  localparam longint ValueMax = 64'sd2147483647;
  localparam longint ValueMin = -64'sd2147483648;

  // One tree node item as the sender drives it.
  typedef struct {
    logic               req;
    logic [15:0]        pd;
    logic [15:0]        pm;
    logic [15:0]        pu;
    logic [9:0]         child;
    logic signed [31:0] ex;
    logic               last;
  } node_req_t;

  // One node value item as the block should return it.
  typedef struct {
    logic signed [31:0] value;
    logic [9:0]         index;
    logic               done;
    logic               err;
  } node_res_t;

  logic clk_i;
  logic rst_ni;

  tbi_in_if  in_if ();
  tbi_out_if out_if ();

  trinomial_backward_induction #(
    .MAX_NODES(MaxNodes)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted state of the ping-pong value store.
  logic signed [31:0] value_store [2][MaxNodes];
  bit                 store_bank;
  int                 level_pos;
  int                 prev_level_size;

  node_res_t expected_nodes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int check_failures;
  int nodes_sent;
  int values_checked;
  int levels_closed;
  int errors_predicted;
  int quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Works out the node value of one item and updates the predicted store.
  function automatic bit induct_node(input node_req_t n, output node_res_t r);
    longint             sum;
    longint             rounded;
    logic signed [31:0] val;
    bit                 err;
    int                 pos;
    pos = level_pos;
    val = n.ex;
    err = 1'b0;
    if (n.req == tbi_pkg::ReqInterior) begin
      if (n.child == 0 || int'(n.child) + 1 >= prev_level_size) begin
        err = 1'b1;
      end else begin
        sum = longint'(n.pd) * longint'(value_store[~store_bank][n.child - 1])
            + longint'(n.pm) * longint'(value_store[~store_bank][n.child])
            + longint'(n.pu) * longint'(value_store[~store_bank][n.child + 1]);
        // Round half up to Q16.16, then clamp to the 32-bit range.
        rounded = (sum + 64'sd32768) >>> 16;
        if (rounded > ValueMax) rounded = ValueMax;
        if (rounded < ValueMin) rounded = ValueMin;
        val = (rounded < longint'(n.ex)) ? n.ex : rounded[31:0];
      end
    end
    r.value = val;
    r.index = pos[9:0];
    r.done  = n.last;
    r.err   = err;
    if (pos < MaxNodes) begin
      value_store[store_bank][pos] = val;
      level_pos = pos + 1;
    end
    if (n.last) begin
      prev_level_size = level_pos;
      level_pos = 0;
      store_bank = ~store_bank;
    end
    return n.req == tbi_pkg::ReqInterior;
  endfunction

  function automatic node_req_t node_of(input logic req, input logic [15:0] pd,
                                        input logic [15:0] pm, input logic [15:0] pu,
                                        input logic [9:0] child,
                                        input logic signed [31:0] ex, input logic last);
    node_req_t n;
    n.req   = req;
    n.pd    = pd;
    n.pm    = pm;
    n.pu    = pu;
    n.child = child;
    n.ex    = ex;
    n.last  = last;
    return n;
  endfunction

  // Random node: mostly children inside the last level, some stray indexes.
  function automatic node_req_t random_node(input bit terminal_level, input bit last);
    node_req_t   n;
    int unsigned pd;
    int unsigned pm;
    n.req = terminal_level ? tbi_pkg::ReqTerminal : tbi_pkg::ReqInterior;
    if (!terminal_level && $urandom_range(19) == 0) n.req = tbi_pkg::ReqTerminal;
    case ($urandom_range(3))
      0: begin
        n.pd = 16'($urandom);
        n.pm = 16'($urandom);
        n.pu = 16'($urandom);
      end
      1: begin
        // Weights that add up to 16'hFFFF, just under one.
        pd = $urandom_range(16'hFFFF);
        pm = $urandom_range(16'hFFFF - pd);
        n.pd = 16'(pd);
        n.pm = 16'(pm);
        n.pu = 16'(16'hFFFF - pd - pm);
      end
      2: begin
        n.pd = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        n.pm = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        n.pu = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        n.pd = 16'($urandom_range(16'h00FF));
        n.pm = 16'($urandom_range(16'h00FF));
        n.pu = 16'($urandom_range(16'h00FF));
      end
    endcase
    if (prev_level_size >= 3 && $urandom_range(9) != 0) begin
      n.child = 10'($urandom_range(prev_level_size - 2, 1));
    end else begin
      n.child = 10'($urandom_range(1023));
    end
    case ($urandom_range(5))
      0:       n.ex = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2:    n.ex = $urandom;
      default: n.ex = $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
    n.last = last;
    return n;
  endfunction

  // Sends one item, idling first as the current phase asks.
  task automatic push_node(input node_req_t n);
    node_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= n.req;
    in_if.prob_down      <= n.pd;
    in_if.prob_mid       <= n.pm;
    in_if.prob_up        <= n.pu;
    in_if.child_index    <= n.child;
    in_if.exercise_value <= n.ex;
    in_if.level_last     <= n.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (induct_node(n, r)) begin
      expected_nodes.push_back(r);
      if (r.err) errors_predicted++;
    end
    nodes_sent++;
    if (n.last) levels_closed++;
  endtask

  // Interior items before any level has ended have no children at all.
  task automatic test_before_first_level();
    push_node(node_of(tbi_pkg::ReqInterior, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd5,
                      32'sh7FFF_FFFF, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h0000, 16'h0000, 16'h0000, 10'd0,
                      32'sh8000_0000, 1'b0));
    push_node(node_of(tbi_pkg::ReqTerminal, 16'h0000, 16'h0000, 16'h0000, 10'd1023,
                      32'sh0001_0000, 1'b1));
  endtask

  // Saturation both ways, rounding, early exercise and the index bounds.
  task automatic test_directed_extremes();
    logic signed [31:0] leaves [8];
    leaves = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0001, -32'sh0000_0001};
    for (int i = 0; i < 8; i++) begin
      push_node(node_of(tbi_pkg::ReqTerminal, 16'h0, 16'h0, 16'h0, 10'd0, leaves[i],
                        i == 7));
    end
    push_node(node_of(tbi_pkg::ReqInterior, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1,
                      32'sh8000_0000, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd4,
                      32'sh8000_0000, 1'b0));
    // A half on each side of zero: one rounds up to 1, the other to 0.
    push_node(node_of(tbi_pkg::ReqInterior, 16'h0000, 16'h8000, 16'h0000, 10'd6,
                      32'sh8000_0000, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h0000, 16'h0000, 16'h8000, 10'd6,
                      32'sh8000_0000, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h0000, 16'h0000, 16'h0000, 10'd6,
                      32'sh0000_0005, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h1234, 16'h5678, 16'h9ABC, 10'd0,
                      32'sh0000_0000, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h1234, 16'h5678, 16'h9ABC, 10'd7,
                      -32'sh0000_0007, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h1234, 16'h5678, 16'h9ABC, 10'd1023,
                      32'sh7FFF_FFFF, 1'b0));
    push_node(node_of(tbi_pkg::ReqTerminal, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd2,
                      32'sh1234_5678, 1'b0));
    push_node(node_of(tbi_pkg::ReqInterior, 16'h5555, 16'h5555, 16'h5555, 10'd2,
                      32'sh8000_0000, 1'b1));
  endtask

  // Well-formed levels with random content, plus stray indexes and items.
  task automatic test_random_levels(input int item_count);
    int  sent;
    int  level_len;
    bit  terminal_level;
    sent = 0;
    while (sent < item_count) begin
      level_len = ($urandom_range(9) == 0) ? $urandom_range(300, 41)
                                           : $urandom_range(40, 1);
      terminal_level = (prev_level_size < 3) || ($urandom_range(7) == 0);
      for (int i = 0; i < level_len; i++) begin
        push_node(random_node(terminal_level, i == level_len - 1));
      end
      sent += level_len;
    end
  endtask

  // Receiver: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    node_res_t e;
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_nodes.size() == 0) begin
        check_failures++;
        if (check_failures <= 10) begin
          $display("unexpected node value item: value %0d index %0d",
                   out_if.node_value, out_if.node_index);
        end
      end else begin
        e = expected_nodes.pop_front();
        values_checked++;
        if (out_if.node_value !== e.value || out_if.node_index !== e.index ||
            out_if.level_done !== e.done || out_if.index_error !== e.err) begin
          check_failures++;
          if (check_failures <= 10) begin
            $display("node mismatch: expected value %0d index %0d done %0b err %0b",
                     e.value, e.index, e.done, e.err);
            $display("               actual   value %0d index %0d done %0b err %0b",
                     out_if.node_value, out_if.node_index, out_if.level_done,
                     out_if.index_error);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("[trinomial_backward_induction] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.req_type       = tbi_pkg::ReqTerminal;
    in_if.prob_down      = '0;
    in_if.prob_mid       = '0;
    in_if.prob_up        = '0;
    in_if.child_index    = '0;
    in_if.exercise_value = '0;
    in_if.level_last     = 1'b0;
    out_if.ready         = 1'b0;
    store_bank           = 1'b0;
    level_pos            = 0;
    prev_level_size      = 0;
    quiet_cycles         = 0;
    check_failures       = 0;
    nodes_sent           = 0;
    values_checked       = 0;
    levels_closed        = 0;
    errors_predicted     = 0;
    send_idle_pct        = 29;
    recv_idle_pct        = 66;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_first_level();
    test_directed_extremes();
    test_random_levels(280);

    send_idle_pct = 66;
    recv_idle_pct = 29;
    test_random_levels(280);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_levels(270);

    in_if.valid <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    check_failures += expected_nodes.size();

    $display("Sent %0d node items over %0d levels under three back-pressure patterns.",
             nodes_sent, levels_closed);
    $display("Checked %0d node values, %0d of them with a child index out of range.",
             values_checked, errors_predicted);
    if (check_failures == 0) begin
      $display("[trinomial_backward_induction] OK");
    end else begin
      $display("[trinomial_backward_induction] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tbi_pkg.sv
rtl/core/tbi_if.sv
rtl/core/tbi_front.sv
rtl/core/tbi_queue.sv
rtl/core/tbi_back.sv
rtl/core/trinomial_backward_induction.sv
rtl/core/tbi_checker.sv
bench/tb_trinomial_backward_induction.sv
